### design/ctb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants of the coincidence track builder
// Request and response payloads, queue command, register indexes, back-end
// state encoding.
// ----------------------------------------------------------------------------
package ctb_pkg;

   localparam int MAX_HITS  = 16;
   localparam int NUM_BARS  = 128;
   localparam int CNT_W     = $clog2(MAX_HITS + 1);

   localparam int TIME_W    = 64;
   localparam int BAR_W     = 7;
   localparam int TAG_W     = 16;
   localparam int HITS_W    = 5;
   localparam int WINDOW_W  = 32;
   localparam int LAYERS_W  = 5;
   localparam int COUNTER_W = 32;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYERS = 1'd1;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd20000;
   localparam logic [LAYERS_W-1:0] LAYERS_RESET = 5'd8;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = CMD_PTR_W + 1;

   typedef struct packed {
      logic [TIME_W-1:0] hit_time;
      logic [BAR_W-1:0]  bar_index;
      logic [TAG_W-1:0]  hit_tag;
      logic              end_of_stream;
   } req_type;

   typedef struct packed {
      logic [BAR_W-1:0]     out_bar_index;
      logic [TIME_W-1:0]    out_hit_time;
      logic [TAG_W-1:0]     out_hit_tag;
      logic                 last_in_track;
      logic [HITS_W-1:0]    track_hits;
      logic                 track_complete;
      logic                 track_overflow;
      logic [COUNTER_W-1:0] complete_tracks;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] hit_time;
      logic [BAR_W-1:0]  bar_index;
      logic [TAG_W-1:0]  hit_tag;
   } hit_type;

   // close_trk: close the open track first; append: then add the hit
   typedef struct packed {
      logic    close_trk;
      logic    append;
      hit_type hit;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DRAIN,
      BK_INSERT
   } back_state_type;

endpackage : ctb_pkg
`default_nettype wire

### design/ctb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_front: request classifier
// Tracks the open track and the previous hit time, decides for each request
// whether it closes the open track and whether it appends a hit.
// ----------------------------------------------------------------------------
module ctb_front import ctb_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire req_type             req_data,
   output logic                     req_stall,
   input  wire logic [WINDOW_W-1:0] window,
   input  wire logic                cmd_full,
   output logic                     cmd_push,
   output cmd_type                  cmd_data
);

   logic              open_ff, open_in;
   logic [TIME_W-1:0] prev_ff, prev_in;
   logic              accept;
   logic              bar_ok;
   logic              hit_go;
   logic [TIME_W-1:0] delta;
   logic              far;

   assign req_stall = cmd_full;
   assign accept    = req_valid & ~req_stall;
   assign bar_ok    = 32'(req_data.bar_index) < NUM_BARS;
   assign hit_go    = ~req_data.end_of_stream & bar_ok;

   // wraps modulo 2^64, so a time going backwards closes the track
   assign delta = req_data.hit_time - prev_ff;
   assign far   = delta >= TIME_W'(window);

   always_comb begin
      cmd_data.close_trk     = open_ff & (req_data.end_of_stream | (hit_go & far));
      cmd_data.append        = hit_go;
      cmd_data.hit.hit_time  = req_data.hit_time;
      cmd_data.hit.bar_index = req_data.bar_index;
      cmd_data.hit.hit_tag   = req_data.hit_tag;
      cmd_push               = accept & (cmd_data.close_trk | cmd_data.append);
   end

   always_comb begin
      open_in = open_ff;
      prev_in = prev_ff;
      if (accept) begin
         if (hit_go) begin
            open_in = 1'b1;
            prev_in = req_data.hit_time;
         end else if (req_data.end_of_stream) begin
            open_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         prev_ff <= '0;
      end else begin
         open_ff <= open_in;
         prev_ff <= prev_in;
      end
   end

endmodule : ctb_front
`default_nettype wire

### design/ctb_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_cmd_fifo: command queue between front and back
// Small show-ahead queue so that classification and track output stall
// independently.
// ----------------------------------------------------------------------------
module ctb_cmd_fifo import ctb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         empty
);

   cmd_type                mem [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = cnt_ff == CMD_CNT_W'(CMD_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule : ctb_cmd_fifo
`default_nettype wire

### design/ctb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_back: track store and sorted output
// Keeps the open track sorted by bar index (high to low, stable) as hits are
// inserted, then shifts the closed track out one response per unstalled cycle.
// ----------------------------------------------------------------------------
module ctb_back import ctb_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [LAYERS_W-1:0] layers,
   input  wire cmd_type             cmd_data,
   input  wire logic                cmd_empty,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_data
);

   back_state_type       state_ff, state_in;
   hit_type              ent_ff [MAX_HITS];
   hit_type              ent_in [MAX_HITS];
   hit_type              shifted [MAX_HITS];
   hit_type              inserted [MAX_HITS];
   logic [MAX_HITS-1:0]  ge;
   logic [CNT_W-1:0]     count_ff;
   logic                 ovf_ff;
   logic [CNT_W-1:0]     left_ff;
   logic [CNT_W-1:0]     trk_n_ff;
   logic                 trk_cmp_ff;
   logic                 trk_ovf_ff;
   logic                 pend_valid_ff;
   hit_type              pend_hit_ff;
   logic [COUNTER_W-1:0] counter_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 start_close;
   logic                 ins_go;
   hit_type              ins_hit;
   logic                 drain_step;
   logic                 has_room;
   logic                 complete;

   assign has_room = 32'(count_ff) < MAX_HITS;
   assign complete = 32'(count_ff) == 32'(layers);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (start_close) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (drain_step && left_ff == CNT_W'(1)) begin
               state_in = pend_valid_ff ? BK_INSERT : BK_IDLE;
            end
         end
         BK_INSERT: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop     = 1'b0;
      start_close = 1'b0;
      ins_go      = 1'b0;
      ins_hit     = cmd_data.hit;
      drain_step  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_pop     = ~cmd_empty;
            start_close = ~cmd_empty & cmd_data.close_trk & (count_ff != '0);
            ins_go      = ~cmd_empty & cmd_data.append & ~start_close;
         end
         BK_DRAIN: begin
            drain_step = ~rsp_valid_ff | ~rsp_stall;
         end
         BK_INSERT: begin
            ins_go  = 1'b1;
            ins_hit = pend_hit_ff;
         end
      endcase
   end

   // entries are kept sorted, so entries at or above the new bar form a prefix
   always_comb begin
      for (int i = 0; i < MAX_HITS; i++) begin
         ge[i] = (CNT_W'(i) < count_ff) && (ent_ff[i].bar_index >= ins_hit.bar_index);
      end
      for (int i = 0; i < MAX_HITS - 1; i++) begin
         shifted[i] = ent_ff[i+1];
      end
      shifted[MAX_HITS-1] = ent_ff[MAX_HITS-1];
      inserted[0] = ge[0] ? ent_ff[0] : ins_hit;
      for (int i = 1; i < MAX_HITS; i++) begin
         if (ge[i]) begin
            inserted[i] = ent_ff[i];
         end else if (ge[i-1]) begin
            inserted[i] = ins_hit;
         end else begin
            inserted[i] = ent_ff[i-1];
         end
      end
      for (int i = 0; i < MAX_HITS; i++) begin
         if (drain_step) begin
            ent_in[i] = shifted[i];
         end else if (ins_go && has_room) begin
            ent_in[i] = inserted[i];
         end else begin
            ent_in[i] = ent_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_HITS; i++) begin
         ent_ff[i] <= ent_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (start_close) begin
         trk_n_ff   <= count_ff;
         trk_cmp_ff <= complete;
         trk_ovf_ff <= ovf_ff;
      end
      if (start_close) begin
         pend_hit_ff <= cmd_data.hit;
      end
      if (drain_step) begin
         rsp_data_ff.out_bar_index   <= ent_ff[0].bar_index;
         rsp_data_ff.out_hit_time    <= ent_ff[0].hit_time;
         rsp_data_ff.out_hit_tag     <= ent_ff[0].hit_tag;
         rsp_data_ff.last_in_track   <= left_ff == CNT_W'(1);
         rsp_data_ff.track_hits      <= HITS_W'(trk_n_ff);
         rsp_data_ff.track_complete  <= trk_cmp_ff;
         rsp_data_ff.track_overflow  <= trk_ovf_ff;
         rsp_data_ff.complete_tracks <= counter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         left_ff       <= '0;
         pend_valid_ff <= 1'b0;
         counter_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start_close) begin
            count_ff      <= '0;
            ovf_ff        <= 1'b0;
            left_ff       <= count_ff;
            pend_valid_ff <= cmd_data.append;
            if (complete && counter_ff != '1) begin
               counter_ff <= counter_ff + 1'b1;
            end
         end else if (ins_go) begin
            if (has_room) begin
               count_ff <= count_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
            if (state_ff == BK_INSERT) begin
               pend_valid_ff <= 1'b0;
            end
         end
         if (drain_step) begin
            left_ff      <= left_ff - 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : ctb_back
`default_nettype wire

### design/coincidence_track_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coincidence_track_builder: time-coincidence track builder
// Groups time-ordered hits into tracks by a coincidence window and sends
// each closed track out sorted by bar index, high to low.
// ----------------------------------------------------------------------------
//  channel   direction  ports                          payload
//  req       in         req_valid/req_stall/req_data   req_type (one hit or flush)
//  rsp       out        rsp_valid/rsp_stall/rsp_data   rsp_type (one hit of a track)
//  csr       in         csr_we/csr_index/csr_wdata     window, layer count
//
//  A request is classified and queued in its cycle; the back end inserts a
//  hit as it pops the command, so hits joining a track go at one per cycle
//  while no track is closing. Closing a track drains it, shifting the n
//  responses out of the sorted track store one per cycle unless rsp_stall
//  holds them, and then inserts the hit, if any, that caused the close.
//  Reset is synchronous; no clearing pass, window resets to 20000, layers to 8.
//  req_stall rises only when the four-entry command queue is full; rsp_stall
//  holds the output register and, through it, the back end.
// ----------------------------------------------------------------------------
module coincidence_track_builder import ctb_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [WINDOW_W-1:0] window_ff;
   logic [LAYERS_W-1:0] layers_ff;
   logic                cmd_push;
   cmd_type             cmd_push_data;
   logic                cmd_full;
   logic                cmd_pop;
   cmd_type             cmd_pop_data;
   logic                cmd_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         layers_ff <= LAYERS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW: window_ff <= WINDOW_W'(csr_wdata);
            CSR_LAYERS: layers_ff <= LAYERS_W'(csr_wdata);
         endcase
      end
   end

   ctb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .window    (window_ff),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_push_data)
   );

   ctb_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .empty     (cmd_empty)
   );

   ctb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .layers    (layers_ff),
      .cmd_data  (cmd_pop_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // front never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset) cmd_push |-> !cmd_full)
      else $error("command pushed into full queue");

   // back never pops an empty queue
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> !cmd_empty)
      else $error("command popped from empty queue");

   // a track drains without gaps once its first response is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_in_track) |=> rsp_valid)
      else $error("gap inside a track");

   // every response belongs to a nonempty track within capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.track_hits != '0 &&
                     32'(rsp_data.track_hits) <= MAX_HITS))
      else $error("track size out of range");

endmodule : coincidence_track_builder
`default_nettype wire

### test/coincidence_track_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coincidence_track_builder_tb: self-checking bench for the track builder
// Feeds hits, some out of time order, and flush requests under changing window
// and layer settings, random request gaps and random response stall. A scoreboard
// rebuilds the tracks, sorts them by bar and checks every response field in order.
// ----------------------------------------------------------------------------
module coincidence_track_builder_tb;
   import ctb_pkg::*;

   // rebuilds tracks from accepted requests and holds the hits still to come out
   class track_scoreboard;
      logic [WINDOW_W-1:0]  window;
      logic [LAYERS_W-1:0]  layers;
      hit_type              held[MAX_HITS];
      int                   held_count;
      logic [TIME_W-1:0]    last_time;
      bit                   overflowed;
      logic [COUNTER_W-1:0] complete_count;
      rsp_type              pending_hits[$];
      int                   errors;

      function new();
         window = WINDOW_RESET;
         layers = LAYERS_RESET;
         held_count = 0;
         last_time = '0;
         overflowed = 1'b0;
         complete_count = '0;
         errors = 0;
      endfunction

      function void close_track();
         int      order[MAX_HITS];
         int      key;
         int      j;
         bit      complete;
         rsp_type r;
         if (held_count == 0) return;
         for (int i = 0; i < held_count; i++) order[i] = i;
         // stable insertion sort, highest bar first
         for (int i = 1; i < held_count; i++) begin
            key = order[i];
            j = i;
            while (j > 0 && held[order[j-1]].bar_index < held[key].bar_index) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = key;
         end
         complete = (held_count == int'(layers));
         if (complete && complete_count != '1) complete_count++;
         for (int i = 0; i < held_count; i++) begin
            r.out_bar_index   = held[order[i]].bar_index;
            r.out_hit_time    = held[order[i]].hit_time;
            r.out_hit_tag     = held[order[i]].hit_tag;
            r.last_in_track   = (i + 1 == held_count);
            r.track_hits      = HITS_W'(held_count);
            r.track_complete  = complete;
            r.track_overflow  = overflowed;
            r.complete_tracks = complete_count;
            pending_hits.insert(pending_hits.size(), r);
         end
         held_count = 0;
         overflowed = 1'b0;
      endfunction

      function void note_request(req_type item);
         if (item.end_of_stream) begin
            close_track();
            return;
         end
         if (int'(item.bar_index) >= NUM_BARS) return;
         if (held_count != 0 && (item.hit_time - last_time) >= {32'd0, window})
            close_track();
         if (held_count < MAX_HITS) begin
            held[held_count].hit_time  = item.hit_time;
            held[held_count].bar_index = item.bar_index;
            held[held_count].hit_tag   = item.hit_tag;
            held_count++;
         end else begin
            overflowed = 1'b1;
         end
         last_time = item.hit_time;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_hits.size() == 0) begin
            $error("response with no track hit pending: %h", got);
            errors++;
            return;
         end
         want = pending_hits.pop_front();
         if (got.out_bar_index !== want.out_bar_index) begin
            $error("out_bar_index: expected %0d, got %0d", want.out_bar_index,
                   got.out_bar_index);
            errors++;
         end
         if (got.out_hit_time !== want.out_hit_time) begin
            $error("out_hit_time: expected %h, got %h", want.out_hit_time, got.out_hit_time);
            errors++;
         end
         if (got.out_hit_tag !== want.out_hit_tag) begin
            $error("out_hit_tag: expected %h, got %h", want.out_hit_tag, got.out_hit_tag);
            errors++;
         end
         if (got.last_in_track !== want.last_in_track) begin
            $error("last_in_track: expected %0d, got %0d", want.last_in_track,
                   got.last_in_track);
            errors++;
         end
         if (got.track_hits !== want.track_hits) begin
            $error("track_hits: expected %0d, got %0d", want.track_hits, got.track_hits);
            errors++;
         end
         if (got.track_complete !== want.track_complete) begin
            $error("track_complete: expected %0d, got %0d", want.track_complete,
                   got.track_complete);
            errors++;
         end
         if (got.track_overflow !== want.track_overflow) begin
            $error("track_overflow: expected %0d, got %0d", want.track_overflow,
                   got.track_overflow);
            errors++;
         end
         if (got.complete_tracks !== want.complete_tracks) begin
            $error("complete_tracks: expected %0d, got %0d", want.complete_tracks,
                   got.complete_tracks);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_WINDOW;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   track_scoreboard   tracks = new();
   int                send_pct = 0;
   int                stall_pct = 0;
   logic [TIME_W-1:0] stream_time = '0;

   coincidence_track_builder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracks.check_response(rsp_data);
   end

   // called just after a rising edge; returns at the edge that took the request, or after the random gap behind it
   task automatic send_request(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      tracks.note_request(item);
      gap = 0;
      while ($urandom_range(0, 99) < send_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_hit(input logic [TIME_W-1:0] t, input logic [BAR_W-1:0] bar,
                           input logic [TAG_W-1:0] tag);
      req_type item;
      item.hit_time      = t;
      item.bar_index     = bar;
      item.hit_tag       = tag;
      item.end_of_stream = 1'b0;
      send_request(item);
   endtask

   task automatic send_random_hit();
      logic [BAR_W-1:0] bar;
      // a few bars only now and then, so equal indexes meet in one track
      if ($urandom_range(0, 3) == 0) bar = BAR_W'($urandom_range(0, 3));
      else bar = BAR_W'($urandom_range(0, NUM_BARS - 1));
      send_hit(stream_time, bar, TAG_W'($urandom));
   endtask

   task automatic send_flush();
      req_type item;
      item.hit_time      = {$urandom, $urandom};
      item.bar_index     = BAR_W'($urandom);
      item.hit_tag       = TAG_W'($urandom);
      item.end_of_stream = 1'b1;
      send_request(item);
   endtask

   // let queued hits land before touching the registers
   task automatic settle();
      req_valid <= 1'b0;
      while (tracks.pending_hits.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic program_config(input logic [CSR_DATA_W-1:0] window_word,
                                 input logic [CSR_DATA_W-1:0] layers_word);
      csr_we    <= 1'b1;
      csr_index <= CSR_WINDOW;
      csr_wdata <= window_word;
      @(posedge clock);
      tracks.window = window_word;
      csr_index <= CSR_LAYERS;
      csr_wdata <= layers_word;
      @(posedge clock);
      tracks.layers = layers_word[LAYERS_W-1:0];
      csr_we <= 1'b0;
   endtask

   function automatic logic [TIME_W-1:0] join_step(input logic [WINDOW_W-1:0] w);
      if (w == 0) return TIME_W'($urandom_range(0, 3));
      if ($urandom_range(0, 4) == 0) return {32'd0, w - 1};
      return {32'd0, $urandom % w};
   endfunction

   function automatic logic [TIME_W-1:0] close_step(input logic [WINDOW_W-1:0] w);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return {32'd0, w};
      if (pick < 8) return {32'd0, w} + TIME_W'($urandom_range(0, 5000));
      // may wrap, which looks like time going backwards
      return {$urandom, $urandom};
   endfunction

   task automatic run_phase(input logic [CSR_DATA_W-1:0] window_word,
                            input logic [CSR_DATA_W-1:0] layers_word,
                            input int sender_idle, input int receiver_stall,
                            input int item_total);
      int sent;
      int pick;
      int track_len;
      settle();
      program_config(window_word, layers_word);
      send_pct  = sender_idle;
      stall_pct = receiver_stall;
      sent = 0;
      while (sent < item_total) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_flush();
            sent++;
         end else if (pick < 12) begin
            stream_time = {$urandom, $urandom};
            send_random_hit();
            sent++;
         end else begin
            // favor tracks that match the layer count, some long enough to overflow
            if ($urandom_range(0, 3) == 0 && tracks.layers >= 1 && tracks.layers <= MAX_HITS)
               track_len = int'(tracks.layers);
            else
               track_len = $urandom_range(1, MAX_HITS + 4);
            stream_time += close_step(window_word);
            send_random_hit();
            sent++;
            repeat (track_len - 1) begin
               stream_time += join_step(window_word);
               send_random_hit();
               sent++;
            end
         end
      end
      if ($urandom_range(0, 1) == 1) send_flush();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // window 20000, layers 8 out of reset
      send_hit(64'd0, 7'd0, 16'h0000);
      send_hit(64'd19999, 7'd127, 16'hFFFF);
      send_hit(64'd19999, 7'd127, 16'h1234);
      send_hit(64'd39998, 7'd64, 16'h0001);
      send_hit(64'd59998, 7'd5, 16'h0002);
      send_hit(64'd10, 7'd9, 16'h0003);
      send_flush();
      send_flush();
      for (int i = 0; i < 7; i++)
         send_hit(64'hFFFF_FFFF_FFFF_0000 + i, BAR_W'(i * 37), TAG_W'(~i));
      send_hit(64'hFFFF_FFFF_FFFF_FFFF, 7'd127, 16'h0000);
      send_hit(64'd0, 7'd0, 16'hFFFF);
      send_flush();

      run_phase(32'd20000, 32'd8, 0, 0, 70);
      run_phase(32'd0, 32'd1, 67, 0, 70);
      run_phase(32'hFFFF_FFFF, 32'd16, 0, 67, 70);
      run_phase(32'd1000, 32'd0, 6, 6, 70);
      run_phase(32'd50, 32'hFFFF_FFFF, 67, 0, 70);
      run_phase(32'd3000, 32'd5, 6, 6, 70);

      send_flush();
      settle();
      if (tracks.errors == 0 && tracks.pending_hits.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule : coincidence_track_builder_tb

### coincidence_track_builder.f
design/ctb_pkg.sv
design/ctb_front.sv
design/ctb_cmd_fifo.sv
design/ctb_back.sv
design/coincidence_track_builder.sv
test/coincidence_track_builder_tb.sv
